### hw/rtl/focvm_pkg.sv
`timescale 1ns / 1ps

package focvm_pkg;

    // Configuration register map.
    localparam int unsigned SUPPLY_W = 15;
    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned PADDR_W  = 3;
    localparam logic [PADDR_W-1:0] ADDR_SUPPLY = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_PERIOD = 3'd4;
    localparam logic [SUPPLY_W-1:0] SUPPLY_RESET = 15'd3072;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd8399;

    // Fixed field widths.
    localparam int unsigned Q_W   = 16;
    localparam int unsigned CMP_W = 16;
    localparam int unsigned LANES = 3;

    // CORDIC constants: 24 rotations on a 32-bit turn angle, gain 2^30.
    localparam int unsigned CORDIC_STEPS = 24;
    localparam int unsigned CORDIC_W     = 33;
    localparam int unsigned ANGLE_W      = 32;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic signed [31:0] SQRT3_Q30 = 32'sd1859775393;

    // Quadrant codes after rounding the angle to the nearest quarter turn.
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // Quotient bits of the duty divider.
    localparam int unsigned DIV_STEPS = 16;
    localparam int unsigned DIV_W     = 31;

    typedef struct packed {
        logic [SUPPLY_W-1:0] supply;
        logic [PERIOD_W-1:0] period;
    } cfg_t;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic [ANGLE_W-1:0] atan_turn(input int unsigned idx);
        logic [ANGLE_W-1:0] r;
        case (idx)
            0:  r = 32'd536870912;
            1:  r = 32'd316933406;
            2:  r = 32'd167458907;
            3:  r = 32'd85004756;
            4:  r = 32'd42667331;
            5:  r = 32'd21354465;
            6:  r = 32'd10679838;
            7:  r = 32'd5340245;
            8:  r = 32'd2670163;
            9:  r = 32'd1335087;
            10: r = 32'd667544;
            11: r = 32'd333772;
            12: r = 32'd166886;
            13: r = 32'd83443;
            14: r = 32'd41722;
            15: r = 32'd20861;
            16: r = 32'd10430;
            17: r = 32'd5215;
            18: r = 32'd2608;
            19: r = 32'd1304;
            20: r = 32'd652;
            21: r = 32'd326;
            22: r = 32'd163;
            23: r = 32'd81;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/focvm_cmd_if.sv
`timescale 1ns / 1ps

interface focvm_cmd_if #(
    parameter int ANGLE_BITS = 16
);
    logic                   valid;
    logic                   ready;
    logic signed [15:0]     q_voltage;
    logic [ANGLE_BITS-1:0]  elec_angle;

    modport source (output valid, output q_voltage, output elec_angle, input ready);
    modport sink (input valid, input q_voltage, input elec_angle, output ready);
endinterface

### hw/rtl/focvm_cmp_if.sv
`timescale 1ns / 1ps

interface focvm_cmp_if;
    logic        valid;
    logic        ready;
    logic [15:0] compare_a;
    logic [15:0] compare_b;
    logic [15:0] compare_c;

    modport source (output valid, output compare_a, output compare_b, output compare_c,
                    input ready);
    modport sink (input valid, input compare_a, input compare_b, input compare_c,
                  output ready);
endinterface

### hw/rtl/focvm_regs.sv
`timescale 1ns / 1ps

module focvm_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [focvm_pkg::PADDR_W-1:0]      paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    output focvm_pkg::cfg_t                    cfg
);

    focvm_pkg::cfg_t cfg_reg;
    logic            wr_en;
    logic            sel_period;

    assign pready     = 1'b1;
    assign wr_en      = psel && penable && pwrite;
    // Registers sit on a four-byte stride; bit 2 selects between them.
    assign sel_period = paddr[2];

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.supply <= focvm_pkg::SUPPLY_RESET;
            cfg_reg.period <= focvm_pkg::PERIOD_RESET;
        end
        else if (wr_en)
        begin
            if (sel_period)
                cfg_reg.period <= pwdata[focvm_pkg::PERIOD_W-1:0];
            else
                cfg_reg.supply <= pwdata[focvm_pkg::SUPPLY_W-1:0];
        end
    end

    // Read data.
    always_comb
    begin
        if (sel_period)
            prdata = {16'd0, cfg_reg.period};
        else
            prdata = {17'd0, cfg_reg.supply};
    end

    assign cfg = cfg_reg;

endmodule

### hw/rtl/focvm_cordic.sv
`timescale 1ns / 1ps

module focvm_cordic #(
    parameter int ANGLE_BITS = 16,
    parameter int SIDE_W     = 16
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        en,
    input  logic                                        in_valid,
    input  logic [ANGLE_BITS-1:0]                       angle,
    input  logic [SIDE_W-1:0]                           side_in,
    output logic                                        out_valid,
    output logic signed [focvm_pkg::CORDIC_W-1:0]       x_out,
    output logic signed [focvm_pkg::CORDIC_W-1:0]       y_out,
    output logic [1:0]                                  quad_out,
    output logic [SIDE_W-1:0]                           side_out
);

    localparam int N  = focvm_pkg::CORDIC_STEPS;
    localparam int CW = focvm_pkg::CORDIC_W;
    localparam int ZW = focvm_pkg::ANGLE_W;

    logic [ZW-1:0]        turn;
    logic [ZW-1:0]        turn_off;
    logic signed [ZW-1:0] z_init;

    logic signed [CW-1:0] x_prev [N];
    logic signed [CW-1:0] y_prev [N];
    logic signed [ZW-1:0] z_prev [N];
    logic [1:0]           quad_prev [N];
    logic [SIDE_W-1:0]    side_prev [N];
    logic                 valid_prev [N];

    logic signed [CW-1:0] x_next [N];
    logic signed [CW-1:0] y_next [N];
    logic signed [ZW-1:0] z_next [N];

    logic signed [CW-1:0] x_reg [N];
    logic signed [CW-1:0] y_reg [N];
    logic signed [ZW-1:0] z_reg [N];
    logic [1:0]           quad_reg [N];
    logic [SIDE_W-1:0]    side_reg [N];
    logic                 valid_reg [N];

    // Reduce the angle to the nearest quarter turn.
    assign turn     = {angle, {(ZW-ANGLE_BITS){1'b0}}};
    assign turn_off = turn + 32'h2000_0000;
    assign z_init   = $signed({2'b00, turn_off[29:0]}) - 32'sh2000_0000;

    assign x_prev[0]     = focvm_pkg::CORDIC_GAIN;
    assign y_prev[0]     = '0;
    assign z_prev[0]     = z_init;
    assign quad_prev[0]  = turn_off[31:30];
    assign side_prev[0]  = side_in;
    assign valid_prev[0] = in_valid;

    for (genvar k = 1; k < N; k++)
    begin : g_link
        assign x_prev[k]     = x_reg[k-1];
        assign y_prev[k]     = y_reg[k-1];
        assign z_prev[k]     = z_reg[k-1];
        assign quad_prev[k]  = quad_reg[k-1];
        assign side_prev[k]  = side_reg[k-1];
        assign valid_prev[k] = valid_reg[k-1];
    end

    // One rotation per stage.
    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            if (!z_prev[k][ZW-1])
            begin
                x_next[k] = x_prev[k] - (y_prev[k] >>> k);
                y_next[k] = y_prev[k] + (x_prev[k] >>> k);
                z_next[k] = z_prev[k] - $signed(focvm_pkg::atan_turn(k));
            end
            else
            begin
                x_next[k] = x_prev[k] + (y_prev[k] >>> k);
                y_next[k] = y_prev[k] - (x_prev[k] >>> k);
                z_next[k] = z_prev[k] + $signed(focvm_pkg::atan_turn(k));
            end
        end
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < N; k++)
                valid_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            for (int k = 0; k < N; k++)
                valid_reg[k] <= valid_prev[k];
        end
    end

    // Stage data.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N; k++)
            begin
                x_reg[k]    <= x_next[k];
                y_reg[k]    <= y_next[k];
                z_reg[k]    <= z_next[k];
                quad_reg[k] <= quad_prev[k];
                side_reg[k] <= side_prev[k];
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign x_out     = x_reg[N-1];
    assign y_out     = y_reg[N-1];
    assign quad_out  = quad_reg[N-1];
    assign side_out  = side_reg[N-1];

endmodule

### hw/rtl/focvm_phase.sv
`timescale 1ns / 1ps

module focvm_phase #(
    parameter int TRIG_BITS = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    en,
    input  focvm_pkg::cfg_t                         cfg,
    input  logic                                    in_valid,
    input  logic signed [focvm_pkg::CORDIC_W-1:0]   x_in,
    input  logic signed [focvm_pkg::CORDIC_W-1:0]   y_in,
    input  logic [1:0]                              quad,
    input  logic signed [focvm_pkg::Q_W-1:0]        u2_in,
    output logic                                    out_valid,
    output logic [focvm_pkg::DIV_W-1:0]             dividend [focvm_pkg::LANES],
    output logic                                    low [focvm_pkg::LANES],
    output logic                                    high [focvm_pkg::LANES]
);

    localparam int TB  = TRIG_BITS;
    localparam int CW  = focvm_pkg::CORDIC_W;
    localparam int QW  = focvm_pkg::Q_W;
    localparam int SH  = 31 - TB;
    localparam int PW  = TB + 32;
    localparam int CW3 = TB + 1;
    localparam int SW  = TB + 2;
    localparam int XW  = TB + 18;
    localparam int MW  = TB + 16;
    localparam int NW  = MW + focvm_pkg::PERIOD_W;
    localparam int L   = focvm_pkg::LANES;
    localparam logic signed [CW-1:0] RND = CW'(64'sd1 <<< (SH - 1));
    localparam logic signed [CW-1:0] LIM = CW'((64'sd1 <<< (TB - 1)) - 1);
    localparam logic signed [PW-1:0] RND30 = PW'(64'sd1 <<< 29);

    // Round from Q.30 to Q1.(TB-1) and saturate symmetrically.
    function automatic logic signed [TB-1:0] to_trig(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] r;
        r = (v + RND) >>> SH;
        if (r > LIM)
            r = LIM;
        else if (r < -LIM)
            r = -LIM;
        return r[TB-1:0];
    endfunction

    logic                  v_reg [7];

    logic signed [TB-1:0]  xr, yr;
    logic signed [TB-1:0]  cs_next, sn_next;
    logic signed [TB-1:0]  cs1_reg, sn1_reg;
    logic signed [QW-1:0]  u1_reg;

    logic signed [PW-1:0]  prod2_reg;
    logic signed [TB-1:0]  sn2_reg;
    logic signed [QW-1:0]  u2_reg;

    logic signed [PW-1:0]  c3_wide;
    logic signed [CW3-1:0] c3;
    logic signed [SW-1:0]  sb3_reg, sc3_reg;
    logic signed [TB-1:0]  sn3_reg;
    logic signed [QW-1:0]  u3_reg;

    logic signed [XW-1:0]  p4_reg [L];

    logic signed [XW-1:0]  mid2;
    logic signed [XW-1:0]  x5_next [L];
    logic signed [XW-1:0]  x5_reg [L];

    logic signed [XW-1:0]  full;
    logic [MW-1:0]         m6_reg [L];
    logic                  low6_reg [L];
    logic                  high6_reg [L];

    logic [NW-1:0]         n7_reg [L];
    logic                  low7_reg [L];
    logic                  high7_reg [L];

    // Rounding and quadrant mapping.
    assign xr = to_trig(x_in);
    assign yr = to_trig(y_in);

    always_comb
    begin
        case (quad)
            focvm_pkg::QUAD_0:
            begin
                cs_next = xr;
                sn_next = yr;
            end
            focvm_pkg::QUAD_1:
            begin
                cs_next = -yr;
                sn_next = xr;
            end
            focvm_pkg::QUAD_2:
            begin
                cs_next = -xr;
                sn_next = -yr;
            end
            default:
            begin
                cs_next = yr;
                sn_next = -xr;
            end
        endcase
    end

    // sqrt(3) * cos, rounded back to trig precision.
    assign c3_wide = (prod2_reg + RND30) >>> 30;
    assign c3      = c3_wide[CW3-1:0];

    // Phase voltages around mid supply.
    assign mid2 = $signed(XW'({cfg.supply, {TB{1'b0}}}));
    assign full = $signed(XW'({cfg.supply, {(TB+1){1'b0}}}));

    always_comb
    begin
        x5_next[0] = mid2 - (p4_reg[0] <<< 1);
        for (int i = 1; i < L; i++)
            x5_next[i] = p4_reg[i] + mid2;
    end

    // Valid bits of the seven stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 7; k++)
                v_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int k = 1; k < 7; k++)
                v_reg[k] <= v_reg[k-1];
        end
    end

    // Stage data.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cs1_reg   <= cs_next;
            sn1_reg   <= sn_next;
            u1_reg    <= u2_in;

            prod2_reg <= PW'(cs1_reg) * PW'(focvm_pkg::SQRT3_Q30);
            sn2_reg   <= sn1_reg;
            u2_reg    <= u1_reg;

            sb3_reg   <= SW'(c3) + SW'(sn2_reg);
            sc3_reg   <= SW'(sn2_reg) - SW'(c3);
            sn3_reg   <= sn2_reg;
            u3_reg    <= u2_reg;

            p4_reg[0] <= XW'(u3_reg) * XW'(sn3_reg);
            p4_reg[1] <= XW'(u3_reg) * XW'(sb3_reg);
            p4_reg[2] <= XW'(u3_reg) * XW'(sc3_reg);

            for (int i = 0; i < L; i++)
            begin
                x5_reg[i]    <= x5_next[i];
                m6_reg[i]    <= x5_reg[i][MW-1:0];
                low6_reg[i]  <= (x5_reg[i] <= 0);
                high6_reg[i] <= (x5_reg[i] >= full);
                n7_reg[i]    <= NW'(m6_reg[i]) * NW'(cfg.period);
                low7_reg[i]  <= low6_reg[i];
                high7_reg[i] <= high6_reg[i];
            end
        end
    end

    // The 2^(TB+1) part of the divisor is a plain shift of the dividend.
    always_comb
    begin
        for (int i = 0; i < L; i++)
        begin
            dividend[i] = n7_reg[i][NW-1:TB+1];
            low[i]      = low7_reg[i];
            high[i]     = high7_reg[i];
        end
    end

    assign out_valid = v_reg[6];

endmodule

### hw/rtl/focvm_div.sv
`timescale 1ns / 1ps

module focvm_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  focvm_pkg::cfg_t                    cfg,
    input  logic                               in_valid,
    input  logic [focvm_pkg::DIV_W-1:0]        dividend [focvm_pkg::LANES],
    input  logic                               low [focvm_pkg::LANES],
    input  logic                               high [focvm_pkg::LANES],
    output logic                               out_valid,
    output logic [focvm_pkg::CMP_W-1:0]        result [focvm_pkg::LANES]
);

    localparam int N  = focvm_pkg::DIV_STEPS;
    localparam int DW = focvm_pkg::DIV_W;
    localparam int L  = focvm_pkg::LANES;

    logic [DW-1:0] rem_prev [N][L];
    logic          low_prev [N][L];
    logic          high_prev [N][L];
    logic [N-1:0]  q_prev [N][L];
    logic          valid_prev [N];

    logic [DW-1:0] rem_next [N][L];
    logic [N-1:0]  q_next [N][L];

    logic [DW-1:0] rem_reg [N][L];
    logic          low_reg [N][L];
    logic          high_reg [N][L];
    logic [N-1:0]  q_reg [N][L];
    logic          valid_reg [N];

    logic [focvm_pkg::CMP_W-1:0] res_reg [L];
    logic                        res_valid_reg;

    always_comb
    begin
        valid_prev[0] = in_valid;
        for (int i = 0; i < L; i++)
        begin
            rem_prev[0][i]  = dividend[i];
            low_prev[0][i]  = low[i];
            high_prev[0][i] = high[i];
            q_prev[0][i]    = '0;
        end
        for (int k = 1; k < N; k++)
        begin
            valid_prev[k] = valid_reg[k-1];
            for (int i = 0; i < L; i++)
            begin
                rem_prev[k][i]  = rem_reg[k-1][i];
                low_prev[k][i]  = low_reg[k-1][i];
                high_prev[k][i] = high_reg[k-1][i];
                q_prev[k][i]    = q_reg[k-1][i];
            end
        end
    end

    // Restoring division, one quotient bit per stage, most significant first.
    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            for (int i = 0; i < L; i++)
            begin
                rem_next[k][i] = rem_prev[k][i];
                q_next[k][i]   = q_prev[k][i];
                if (rem_prev[k][i] >= (DW'(cfg.supply) << (N - 1 - k)))
                begin
                    rem_next[k][i]        = rem_prev[k][i] - (DW'(cfg.supply) << (N - 1 - k));
                    q_next[k][i][N-1-k]   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < N; k++)
                valid_reg[k] <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            for (int k = 0; k < N; k++)
                valid_reg[k] <= valid_prev[k];
            res_valid_reg <= valid_reg[N-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N; k++)
            begin
                for (int i = 0; i < L; i++)
                begin
                    rem_reg[k][i]  <= rem_next[k][i];
                    q_reg[k][i]    <= q_next[k][i];
                    low_reg[k][i]  <= low_prev[k][i];
                    high_reg[k][i] <= high_prev[k][i];
                end
            end
            // Duty clamp: at or below zero, or at or above full supply.
            for (int i = 0; i < L; i++)
            begin
                if (low_reg[N-1][i])
                    res_reg[i] <= '0;
                else if (high_reg[N-1][i])
                    res_reg[i] <= cfg.period;
                else
                    res_reg[i] <= q_reg[N-1][i];
            end
        end
    end

    assign out_valid = res_valid_reg;

    always_comb
    begin
        for (int i = 0; i < L; i++)
            result[i] = res_reg[i];
    end

endmodule

### hw/rtl/foc_voltage_modulator_top.sv
`timescale 1ns / 1ps

// Voltage-mode output stage for field-oriented control: each command transaction
// (signed Q8.8 q-axis voltage, electrical angle as a fraction of a turn) yields one
// transaction of three timer compare values, after an inverse Park and inverse Clarke
// transform centered on half the supply, a divide by the supply and a scale by the
// timer period. The pipeline takes one transaction every clock cycle unless the
// output stalls, in which case the whole pipeline holds. It is made of 24 stages of
// CORDIC rotation, 7 stages of rounding, multiplication and clamping, and 17 stages
// of a bit-per-stage duty divider. Configuration (supply in unsigned Q7.8 volts at
// address 0, timer period at address 4) is to be written over APB by the user only
// while no transactions are in flight; the block itself does not enforce this.

module foc_voltage_modulator_top #(
    parameter int ANGLE_BITS = 16,
    parameter int TRIG_BITS  = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [focvm_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    focvm_cmd_if.sink                      cmd,
    focvm_cmp_if.source                    cmp
);

    localparam int QW = focvm_pkg::Q_W;
    localparam int CW = focvm_pkg::CORDIC_W;
    localparam int L  = focvm_pkg::LANES;

    focvm_pkg::cfg_t cfg;
    logic            en;

    logic signed [QW:0]   u2_wide;
    logic signed [QW:0]   vpos;
    logic signed [QW-1:0] u2;

    logic                 cor_valid;
    logic signed [CW-1:0] cor_x, cor_y;
    logic [1:0]           cor_quad;
    logic [QW-1:0]        cor_side;

    logic                        ph_valid;
    logic [focvm_pkg::DIV_W-1:0] ph_dividend [L];
    logic                        ph_low [L];
    logic                        ph_high [L];

    logic                        div_valid;
    logic [focvm_pkg::CMP_W-1:0] div_result [L];

    // The whole pipeline advances unless a finished result is waiting.
    assign en        = cmp.ready || !div_valid;
    assign cmd.ready = en;

    focvm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Doubled q voltage clamped to plus or minus the supply.
    assign u2_wide = {cmd.q_voltage, 1'b0};
    assign vpos    = $signed({2'b00, cfg.supply});

    always_comb
    begin
        if (u2_wide > vpos)
            u2 = vpos[QW-1:0];
        else if (u2_wide < -vpos)
            u2 = QW'(-vpos);
        else
            u2 = u2_wide[QW-1:0];
    end

    focvm_cordic #(
        .ANGLE_BITS (ANGLE_BITS),
        .SIDE_W     (QW)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (cmd.valid),
        .angle     (cmd.elec_angle[ANGLE_BITS-1:0]),
        .side_in   (u2),
        .out_valid (cor_valid),
        .x_out     (cor_x),
        .y_out     (cor_y),
        .quad_out  (cor_quad),
        .side_out  (cor_side)
    );

    focvm_phase #(
        .TRIG_BITS (TRIG_BITS)
    ) u_phase (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg),
        .in_valid  (cor_valid),
        .x_in      (cor_x),
        .y_in      (cor_y),
        .quad      (cor_quad),
        .u2_in     ($signed(cor_side)),
        .out_valid (ph_valid),
        .dividend  (ph_dividend),
        .low       (ph_low),
        .high      (ph_high)
    );

    focvm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg),
        .in_valid  (ph_valid),
        .dividend  (ph_dividend),
        .low       (ph_low),
        .high      (ph_high),
        .out_valid (div_valid),
        .result    (div_result)
    );

    assign cmp.valid     = div_valid;
    assign cmp.compare_a = div_result[0];
    assign cmp.compare_b = div_result[1];
    assign cmp.compare_c = div_result[2];

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int LATENCY = 48;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic signed [15:0] q_voltage;
        logic [15:0]        elec_angle;
    } command_t;

    typedef struct packed {
        logic [15:0] compare_a;
        logic [15:0] compare_b;
        logic [15:0] compare_c;
    } compares_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [focvm_pkg::PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    focvm_cmd_if #(.ANGLE_BITS(16)) cmd ();
    focvm_cmp_if cmp ();

    foc_voltage_modulator_top uut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .cmd(cmd.sink), .cmp(cmp.source)
    );

    // Predictor copy of the configuration registers.
    logic [focvm_pkg::SUPPLY_W-1:0] model_supply;
    logic [focvm_pkg::PERIOD_W-1:0] model_period;

    command_t  pending_commands[$];
    compares_t expected_compares[$];
    int mismatch_count = 0;
    int sent_count = 0;
    int checked_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 0;
    bit cmd_accepted = 0;
    int quiet_cycles = 0;

    // Floor division by a power of two for either sign.
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_trig(longint v);
        longint r;
        r = floor_shift(v + (64'sd1 << 14), 15);
        if (r > 32767) r = 32767;
        if (r < -32767) r = -32767;
        return r;
    endfunction

    function automatic longint turn_atan(int i);
        longint t[24] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                          10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                          83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
        return t[i];
    endfunction

    function automatic logic [15:0] duty_compare(longint x, longint supply,
                                                 longint period);
        longint full;
        full = supply <<< 17;
        if (x <= 0) return 16'd0;
        if (x >= full) return period[15:0];
        return 16'((x * period) / full);
    endfunction

    // Expected compare values for one command under the current registers.
    function automatic compares_t modulate(command_t c);
        compares_t r;
        longint v, u2, x, y, z, dx, dy, sn, cs, c3, mid;
        logic [31:0] turn, shifted;
        logic [1:0] quad;
        v = model_supply;
        u2 = 2 * longint'(c.q_voltage);
        if (u2 > v) u2 = v;
        if (u2 < -v) u2 = -v;
        turn = {c.elec_angle, 16'd0};
        shifted = turn + 32'h2000_0000;
        quad = shifted[31:30];
        z = longint'({2'b00, shifted[29:0]}) - 64'sh2000_0000;
        x = 652032874;
        y = 0;
        for (int i = 0; i < 24; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= turn_atan(i);
            end
            else
            begin
                x += dx; y -= dy; z += turn_atan(i);
            end
        end
        x = round_trig(x);
        y = round_trig(y);
        case (quad)
            focvm_pkg::QUAD_0: begin cs = x;  sn = y;  end
            focvm_pkg::QUAD_1: begin cs = -y; sn = x;  end
            focvm_pkg::QUAD_2: begin cs = -x; sn = -y; end
            default: begin cs = y; sn = -x; end
        endcase
        c3 = floor_shift(cs * 1859775393 + (64'sd1 << 29), 30);
        mid = v <<< 15;
        r.compare_a = duty_compare(-2 * u2 * sn + mid * 2, v, model_period);
        r.compare_b = duty_compare(u2 * (c3 + sn) + mid * 2, v, model_period);
        r.compare_c = duty_compare(u2 * (sn - c3) + mid * 2, v, model_period);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        mismatch_count++;
    endtask

    // Clock.
    initial clk = 0;
    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    // Command acceptance is captured at the rising edge where it happens.
    always @(posedge clk)
        cmd_accepted <= cmd.valid && cmd.ready;

    // Command driver: offers queued commands, predicting on acceptance.
    always @(negedge clk)
    begin
        if (cmd_accepted)
        begin
            expected_compares.push_back(modulate(pending_commands.pop_front()));
            sent_count++;
        end
        if (pending_commands.size() > 0
            && ((cmd.valid && !cmd_accepted) || ($urandom_range(99) >= send_idle_pct)))
        begin
            cmd.valid <= 1'b1;
            cmd.q_voltage <= pending_commands[0].q_voltage;
            cmd.elec_angle <= pending_commands[0].elec_angle;
        end
        else
            cmd.valid <= 1'b0;
    end

    // Result ready with random stalls and an optional long hold-off.
    always @(negedge clk)
        cmp.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);

    // Monitor: checks each result transaction against the oldest expectation.
    always @(posedge clk)
    begin
        compares_t want;
        if (cmp.valid && cmp.ready)
        begin
            if (expected_compares.size() == 0)
                report_mismatch("unexpected result transaction", cmp.compare_a, 16'd0);
            else
            begin
                want = expected_compares.pop_front();
                if (cmp.compare_a !== want.compare_a)
                    report_mismatch("compare_a", cmp.compare_a, want.compare_a);
                if (cmp.compare_b !== want.compare_b)
                    report_mismatch("compare_b", cmp.compare_b, want.compare_b);
                if (cmp.compare_c !== want.compare_c)
                    report_mismatch("compare_c", cmp.compare_c, want.compare_c);
            end
            checked_count++;
        end
    end

    // Watchdog on cycles without any accepted transaction.
    always @(posedge clk)
    begin
        if ((cmd.valid && cmd.ready) || (cmp.valid && cmp.ready) || hold_off)
            quiet_cycles <= 0;
        else if (rst_n && (pending_commands.size() > 0 || expected_compares.size() > 0))
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout with %0d results outstanding", expected_compares.size());
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic apb_write(logic [focvm_pkg::PADDR_W-1:0] addr, logic [31:0] data);
        @(negedge clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
        @(negedge clk);
        penable <= 1;
        @(negedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        if (addr == focvm_pkg::ADDR_SUPPLY)
            model_supply = data[focvm_pkg::SUPPLY_W-1:0];
        else if (addr == focvm_pkg::ADDR_PERIOD)
            model_period = data[focvm_pkg::PERIOD_W-1:0];
    endtask

    task automatic drain();
        wait (pending_commands.size() == 0 && !cmd.valid && expected_compares.size() == 0);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    task automatic queue_command(logic [15:0] q, logic [15:0] ang);
        command_t c;
        c.q_voltage = q;
        c.elec_angle = ang;
        pending_commands.push_back(c);
    endtask

    task automatic queue_random(int n);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(4))
                0: queue_command(16'($urandom), 16'($urandom));
                1: queue_command(16'($urandom_range(65535)) >>> 4, 16'($urandom));
                2: queue_command($urandom_range(1) ? 16'h7FFF : 16'h8000, 16'($urandom));
                3: queue_command(16'($urandom), {2'($urandom_range(3)), 14'd0}
                                 + 16'($urandom_range(8)) - 16'd4);
                default: queue_command(16'($urandom_range(2048)) - 16'd1024,
                                       16'($urandom));
            endcase
        end
    endtask

    initial
    begin
        int supplies[6] = '{1, 32767, 3072, 0, 777, 16384};
        int periods[6] = '{65535, 1, 8399, 0, 0, 1000};
        rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        cmd.valid = 0; cmd.q_voltage = '0; cmd.elec_angle = '0;
        cmp.ready = 0;
        model_supply = focvm_pkg::SUPPLY_RESET;
        model_period = focvm_pkg::PERIOD_RESET;
        repeat (5) @(negedge clk);
        rst_n = 1;

        // Directed: field extremes, quarter-turn boundaries, clamping.
        queue_command(16'h0000, 16'h0000);
        queue_command(16'h7FFF, 16'h0000);
        queue_command(16'h8000, 16'h4000);
        queue_command(16'h7FFF, 16'hFFFF);
        queue_command(16'h8000, 16'h8000);
        queue_command(16'h0600, 16'hC000);
        queue_command(16'hFA00, 16'h2000);
        queue_command(16'h0100, 16'h1FFF);
        queue_command(16'h0100, 16'h6000);
        queue_command(16'hFF00, 16'hA000);
        queue_command(16'h0300, 16'hE000);
        queue_command(16'h0001, 16'h5555);
        queue_command(16'hFFFF, 16'hAAAA);
        drain();

        // Register settings cycle through extremes; idle mixes per phase.
        for (int ph = 0; ph < 8; ph++)
        begin
            apb_write(focvm_pkg::ADDR_SUPPLY, supplies[ph % 6]);
            apb_write(focvm_pkg::ADDR_PERIOD, periods[ph % 6]);
            send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? (ph % 4 == 3 ? 23 : 85) : 0;
            recv_stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? (ph % 4 == 3 ? 23 : 85) : 0;
            if (ph == 0)
                queue_command(16'h0000, 16'h0000);
            queue_random(200);
            if (ph == 4)
            begin
                hold_off = 1;
                repeat (300) @(negedge clk);
                hold_off = 0;
            end
            drain();
        end
        apb_write(focvm_pkg::ADDR_SUPPLY, 32'(focvm_pkg::SUPPLY_RESET));
        apb_write(focvm_pkg::ADDR_PERIOD, 32'(focvm_pkg::PERIOD_RESET));
        queue_random(20);
        drain();

        $display("Sent %0d commands, checked %0d compare results", sent_count,
                 checked_count);
        $display("Covered supply and period extremes, saturation and all quadrants");
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### sim.f
hw/rtl/focvm_pkg.sv
hw/rtl/focvm_cmd_if.sv
hw/rtl/focvm_cmp_if.sv
hw/rtl/focvm_regs.sv
hw/rtl/focvm_cordic.sv
hw/rtl/focvm_phase.sv
hw/rtl/focvm_div.sv
hw/rtl/foc_voltage_modulator_top.sv
test/testbench.sv
